### rtl/core/sfbc_pkg.sv
// ----------------------------------------------------------------------------
// sfbc_pkg
// Shared types, constants and helpers of the folded SHA-1 block check.
// ----------------------------------------------------------------------------
package sfbc_pkg;

    localparam int MAX_MESSAGE_BYTES = 4096;
    localparam int COUNT_W           = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam int CHECK_OFFSET = 14;
    localparam int CHECK_BYTES  = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] WORD_IDX_LEN_HI = 4'd14;
    localparam logic [3:0] WORD_IDX_LEN_LO = 4'd15;
    localparam logic [3:0] WORD_IDX_LAST   = 4'd15;
    localparam logic [6:0] ROUND_LAST      = 7'd79;

    localparam logic [31:0] H0 = 32'h6745_2301;
    localparam logic [31:0] H1 = 32'hEFCD_AB89;
    localparam logic [31:0] H2 = 32'h98BA_DCFE;
    localparam logic [31:0] H3 = 32'h1032_5476;
    localparam logic [31:0] H4 = 32'hC3D2_E1F0;

    localparam logic [31:0] K0 = 32'h5A82_7999;
    localparam logic [31:0] K1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K3 = 32'hCA62_C1D6;

    // one message word on its way from front to back
    typedef struct packed {
        logic [31:0] word;
        logic        final_word;
        logic [31:0] stored_check;
        logic        overflow;
    } q_entry_t;

    typedef enum logic [1:0] {
        F_BYTES,
        F_PAD,
        F_FILL
    } front_state_t;

    typedef enum logic [1:0] {
        B_LOAD,
        B_ROUND,
        B_ADD,
        B_FOLD
    } back_state_t;

    // xor of digest bytes 5g..5g+4 gives check byte g
    function automatic logic [31:0] fold_digest(input logic [159:0] d);
        logic [31:0] r;
        logic [7:0]  x;
        r = '0;
        for (int g = 0; g < 4; g++) begin
            x = '0;
            for (int i = 0; i < 5; i++) begin
                x = x ^ d[159 - 8 * (5 * g + i) -: 8];
            end
            r[31 - 8 * g -: 8] = x;
        end
        return r;
    endfunction

endpackage

### rtl/core/sfbc_queue.sv
// ----------------------------------------------------------------------------
// sfbc_queue
// Short word queue between the byte front end and the hash engine.
// ----------------------------------------------------------------------------
module sfbc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_push,
    input  sfbc_pkg::q_entry_t q_wdata,
    output logic               q_full,
    input  logic               q_pop,
    output sfbc_pkg::q_entry_t q_rdata,
    output logic               q_empty
);

    sfbc_pkg::q_entry_t                mem_reg [sfbc_pkg::QUEUE_DEPTH];
    logic [sfbc_pkg::QPTR_W-1:0]       head_reg, head_next;
    logic [sfbc_pkg::QPTR_W-1:0]       tail_reg, tail_next;
    logic [sfbc_pkg::QPTR_W:0]         count_reg, count_next;
    logic                              do_push, do_pop;

    assign q_full  = (count_reg == (sfbc_pkg::QPTR_W+1)'(sfbc_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_rdata = mem_reg[head_reg];

    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    always_comb
    begin
        head_next  = do_pop  ? head_reg + 1'b1 : head_reg;
        tail_next  = do_push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[tail_reg] <= q_wdata;
        end
    end

endmodule

### rtl/core/sfbc_front.sv
// ----------------------------------------------------------------------------
// sfbc_front
// Takes bytes, pulls out the stored check, packs big-endian words and
// appends the SHA-1 padding and bit length at the end of each block.
// ----------------------------------------------------------------------------
module sfbc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               full,
    input  logic               q_full,
    output logic               q_push,
    output sfbc_pkg::q_entry_t q_wdata
);

    localparam int CW = sfbc_pkg::COUNT_W;

    sfbc_pkg::front_state_t state_reg, state_next;
    logic [CW-1:0]          bytes_seen_reg, bytes_seen_next;
    logic [31:0]            stored_check_reg, stored_check_next;
    logic                   overflow_reg, overflow_next;
    logic [23:0]            word_reg, word_next;
    logic [3:0]             idx_reg, idx_next;
    logic                   extra_reg, extra_next;

    logic                   accept;
    logic                   drop;
    logic                   in_check;
    logic [1:0]             check_off;
    logic [1:0]             check_sel;
    logic [7:0]             msg_byte;
    logic [63:0]            bit_len;
    logic [31:0]            pad_word;
    logic                   fill_len;
    logic                   fill_final;

    assign full   = (state_reg != sfbc_pkg::F_BYTES) || q_full;
    assign accept = push && !full;
    assign drop   = (bytes_seen_reg == CW'(sfbc_pkg::MAX_MESSAGE_BYTES));

    assign in_check  = (bytes_seen_reg >= CW'(sfbc_pkg::CHECK_OFFSET)) &&
                       (bytes_seen_reg < CW'(sfbc_pkg::CHECK_OFFSET + sfbc_pkg::CHECK_BYTES));
    assign check_off = 2'(bytes_seen_reg - CW'(sfbc_pkg::CHECK_OFFSET));
    assign check_sel = 2'd3 - check_off;
    assign msg_byte  = in_check ? 8'h00 : data_byte;

    assign bit_len    = 64'(bytes_seen_reg) << 3;
    assign fill_len   = !extra_reg && (idx_reg >= sfbc_pkg::WORD_IDX_LEN_HI);
    assign fill_final = !extra_reg && (idx_reg == sfbc_pkg::WORD_IDX_LAST);

    // first padding word: held bytes, then the 0x80 marker
    always_comb
    begin
        case (bytes_seen_reg[1:0])
            2'd0:    pad_word = 32'h8000_0000;
            2'd1:    pad_word = {word_reg[7:0], 24'h80_0000};
            2'd2:    pad_word = {word_reg[15:0], 16'h8000};
            default: pad_word = {word_reg, 8'h80};
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfbc_pkg::F_BYTES:
            begin
                if (accept && last_byte)
                begin
                    state_next = sfbc_pkg::F_PAD;
                end
            end
            sfbc_pkg::F_PAD:
            begin
                if (!q_full)
                begin
                    state_next = sfbc_pkg::F_FILL;
                end
            end
            sfbc_pkg::F_FILL:
            begin
                if (!q_full && fill_final)
                begin
                    state_next = sfbc_pkg::F_BYTES;
                end
            end
            default:
            begin
                state_next = sfbc_pkg::F_BYTES;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        bytes_seen_next   = bytes_seen_reg;
        stored_check_next = stored_check_reg;
        overflow_next     = overflow_reg;
        word_next         = word_reg;
        idx_next          = idx_reg;
        extra_next        = extra_reg;
        q_push            = 1'b0;
        q_wdata.word         = {word_reg, msg_byte};
        q_wdata.final_word   = 1'b0;
        q_wdata.stored_check = stored_check_reg;
        q_wdata.overflow     = overflow_reg;

        unique case (state_reg)
            sfbc_pkg::F_BYTES:
            begin
                if (accept)
                begin
                    if (drop)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        if (in_check)
                        begin
                            stored_check_next[{check_sel, 3'b000} +: 8] = data_byte;
                        end
                        word_next       = {word_reg[15:0], msg_byte};
                        bytes_seen_next = bytes_seen_reg + 1'b1;
                        q_push          = (bytes_seen_reg[1:0] == 2'd3);
                    end
                end
            end
            sfbc_pkg::F_PAD:
            begin
                q_wdata.word = pad_word;
                q_push       = !q_full;
                if (!q_full)
                begin
                    idx_next   = bytes_seen_reg[5:2] + 1'b1;
                    // marker too late for the length: one more chunk follows
                    extra_next = (bytes_seen_reg[5:2] == sfbc_pkg::WORD_IDX_LEN_HI);
                end
            end
            sfbc_pkg::F_FILL:
            begin
                if (!fill_len)
                begin
                    q_wdata.word = 32'h0;
                end
                else if (idx_reg == sfbc_pkg::WORD_IDX_LEN_HI)
                begin
                    q_wdata.word = bit_len[63:32];
                end
                else
                begin
                    q_wdata.word = bit_len[31:0];
                end
                q_wdata.final_word = fill_final;
                q_push             = !q_full;
                if (!q_full)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == sfbc_pkg::WORD_IDX_LEN_LO)
                    begin
                        extra_next = 1'b0;
                    end
                    if (fill_final)
                    begin
                        bytes_seen_next   = '0;
                        stored_check_next = '0;
                        overflow_next     = 1'b0;
                    end
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sfbc_pkg::F_BYTES;
            bytes_seen_reg   <= '0;
            stored_check_reg <= '0;
            overflow_reg     <= 1'b0;
            idx_reg          <= '0;
            extra_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            bytes_seen_reg   <= bytes_seen_next;
            stored_check_reg <= stored_check_next;
            overflow_reg     <= overflow_next;
            idx_reg          <= idx_next;
            extra_reg        <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

### rtl/core/sfbc_back.sv
// ----------------------------------------------------------------------------
// sfbc_back
// SHA-1 engine: loads 16 words, runs 80 rounds one per cycle, adds into
// the digest and, after the final chunk, folds it into the result register.
// ----------------------------------------------------------------------------
module sfbc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  sfbc_pkg::q_entry_t q_rdata,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        check_value,
    output logic               check_matches,
    output logic               length_overflow
);

    sfbc_pkg::back_state_t state_reg, state_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic [6:0]            round_reg, round_next;
    logic [31:0]           digest_reg [5];
    logic [31:0]           digest_next [5];
    logic [31:0]           sched_reg [16];
    logic [31:0]           sched_next [16];
    logic [31:0]           a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]           a_next, b_next, c_next, d_next, e_next;
    logic                  final_reg, final_next;
    logic [31:0]           stored_reg, stored_next;
    logic                  ovf_reg, ovf_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_check_reg, out_check_next;
    logic                  out_match_reg, out_match_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic [31:0]           f_val, k_val, round_sum, w_new, w_mix, fold_val;
    logic                  load_last;
    logic                  out_write;

    assign empty           = !out_valid_reg;
    assign check_value     = out_check_reg;
    assign check_matches   = out_match_reg;
    assign length_overflow = out_ovf_reg;

    // round function and constant by round group
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sfbc_pkg::K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sfbc_pkg::K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sfbc_pkg::K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sfbc_pkg::K3;
        end
    end

    assign round_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + sched_reg[0];
    // schedule kept as a shift line: slot 0 is the word of the current round
    assign w_mix     = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign w_new     = {w_mix[30:0], w_mix[31]};
    assign fold_val  = sfbc_pkg::fold_digest({digest_reg[0], digest_reg[1], digest_reg[2],
                                              digest_reg[3], digest_reg[4]});

    assign load_last = (cnt_reg == 4'd15);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfbc_pkg::B_LOAD:
            begin
                if (!q_empty && load_last)
                begin
                    state_next = sfbc_pkg::B_ROUND;
                end
            end
            sfbc_pkg::B_ROUND:
            begin
                if (round_reg == sfbc_pkg::ROUND_LAST)
                begin
                    state_next = sfbc_pkg::B_ADD;
                end
            end
            sfbc_pkg::B_ADD:
            begin
                state_next = final_reg ? sfbc_pkg::B_FOLD : sfbc_pkg::B_LOAD;
            end
            sfbc_pkg::B_FOLD:
            begin
                if (!out_valid_reg)
                begin
                    state_next = sfbc_pkg::B_LOAD;
                end
            end
            default:
            begin
                state_next = sfbc_pkg::B_LOAD;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cnt_next    = cnt_reg;
        round_next  = round_reg;
        digest_next = digest_reg;
        sched_next  = sched_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        final_next  = final_reg;
        stored_next = stored_reg;
        ovf_next    = ovf_reg;
        q_pop       = 1'b0;
        out_write   = 1'b0;

        unique case (state_reg)
            sfbc_pkg::B_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    for (int i = 0; i < 15; i++)
                    begin
                        sched_next[i] = sched_reg[i + 1];
                    end
                    sched_next[15] = q_rdata.word;
                    if (load_last)
                    begin
                        final_next  = q_rdata.final_word;
                        stored_next = q_rdata.stored_check;
                        ovf_next    = q_rdata.overflow;
                        round_next  = '0;
                        a_next      = digest_reg[0];
                        b_next      = digest_reg[1];
                        c_next      = digest_reg[2];
                        d_next      = digest_reg[3];
                        e_next      = digest_reg[4];
                    end
                end
            end
            sfbc_pkg::B_ROUND:
            begin
                a_next     = round_sum;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                round_next = round_reg + 1'b1;
                for (int i = 0; i < 15; i++)
                begin
                    sched_next[i] = sched_reg[i + 1];
                end
                sched_next[15] = w_new;
            end
            sfbc_pkg::B_ADD:
            begin
                digest_next[0] = digest_reg[0] + a_reg;
                digest_next[1] = digest_reg[1] + b_reg;
                digest_next[2] = digest_reg[2] + c_reg;
                digest_next[3] = digest_reg[3] + d_reg;
                digest_next[4] = digest_reg[4] + e_reg;
            end
            sfbc_pkg::B_FOLD:
            begin
                if (!out_valid_reg)
                begin
                    out_write      = 1'b1;
                    digest_next[0] = sfbc_pkg::H0;
                    digest_next[1] = sfbc_pkg::H1;
                    digest_next[2] = sfbc_pkg::H2;
                    digest_next[3] = sfbc_pkg::H3;
                    digest_next[4] = sfbc_pkg::H4;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_check_next = out_check_reg;
        out_match_next = out_match_reg;
        out_ovf_next   = out_ovf_reg;
        if (out_write)
        begin
            out_valid_next = 1'b1;
            out_check_next = fold_val;
            out_match_next = (fold_val == stored_reg);
            out_ovf_next   = ovf_reg;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfbc_pkg::B_LOAD;
            cnt_reg       <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            digest_reg[0] <= sfbc_pkg::H0;
            digest_reg[1] <= sfbc_pkg::H1;
            digest_reg[2] <= sfbc_pkg::H2;
            digest_reg[3] <= sfbc_pkg::H3;
            digest_reg[4] <= sfbc_pkg::H4;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
            digest_reg    <= digest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg     <= sched_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        d_reg         <= d_next;
        e_reg         <= e_next;
        final_reg     <= final_next;
        stored_reg    <= stored_next;
        ovf_reg       <= ovf_next;
        out_check_reg <= out_check_next;
        out_match_reg <= out_match_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

### rtl/core/sha1_folded_block_check.sv
// ----------------------------------------------------------------------------
// sha1_folded_block_check
// Bytes go in through push/full, one block at a time with last_byte on the
// final byte; bytes 14 to 17 are kept as the stored check and hashed as
// zeros. The front end takes one byte per cycle while full is low and packs
// words into a four-entry queue, which holds only 16 bytes. The hash engine
// pops one word per cycle while the queue is not empty, then runs 80 rounds
// (one per cycle) and an add step. Once the queue fills during the rounds
// the front end stalls, so the other 48 bytes of the next chunk arrive one
// per cycle while the engine loads; throughput is set by the round loop and
// the byte-wide front end. The end of a block adds one or two padding chunks
// and a fold step. The result (folded digest, match flag and overflow flag)
// is then held on the result ports until popped; the next block can stream
// in meanwhile. Blocks longer than 4096 bytes are hashed over their first
// 4096 bytes and flagged.
// ----------------------------------------------------------------------------
module sha1_folded_block_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] check_value,
    output logic        check_matches,
    output logic        length_overflow
);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    sfbc_pkg::q_entry_t q_wdata;
    sfbc_pkg::q_entry_t q_rdata;

    sfbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .full      (full),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    sfbc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_rdata (q_rdata),
        .q_empty (q_empty)
    );

    sfbc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_rdata         (q_rdata),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .check_value     (check_value),
        .check_matches   (check_matches),
        .length_overflow (length_overflow)
    );

    // front never pushes a word the queue cannot take
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("word pushed into full queue");

    // engine never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // a popped result is not replaced in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) (pop && !empty) |=> empty)
        else $error("result overwritten while being taken");

    // the front end stalls while it emits padding words
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && last_byte) |=> full)
        else $error("byte accepted during padding");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams data blocks of random and boundary lengths into the folded SHA-1
// block check. A scoreboard hashes each block on the side and queues the
// expected check value, match flag and overflow flag. Blocks include ones
// whose bytes 14 to 17 carry their own folded digest, and a block past the
// maximum length. Both sides idle at random, and the receiver holds off once
// long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 300;

    class check_scoreboard;

        typedef struct {
            bit [31:0] value;
            bit        is_match;
            bit        overflow;
        } block_check_t;

        bit [31:0]    digest[5];
        bit [31:0]    sched[16];
        int unsigned  count;
        bit [31:0]    stored;
        bit           overflow;
        block_check_t expected[$];
        int           errors;
        int           results_checked;

        function new();
            errors = 0;
            results_checked = 0;
            clear();
        endfunction

        function void clear();
            digest[0] = sfbc_pkg::H0;
            digest[1] = sfbc_pkg::H1;
            digest[2] = sfbc_pkg::H2;
            digest[3] = sfbc_pkg::H3;
            digest[4] = sfbc_pkg::H4;
            foreach (sched[i]) sched[i] = '0;
            count    = 0;
            stored   = '0;
            overflow = 1'b0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void put_byte(int unsigned pos, bit [7:0] v);
            sched[(pos >> 2) & 15][(3 - (pos & 3)) * 8 +: 8] = v;
        endfunction

        function void compress();
            bit [31:0] a, b, c, d, e, f, k, w, t;
            a = digest[0];
            b = digest[1];
            c = digest[2];
            d = digest[3];
            e = digest[4];
            for (int r = 0; r < 80; r++) begin
                if (r >= 16) begin
                    w = sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^
                        sched[(r - 14) & 15] ^ sched[r & 15];
                    sched[r & 15] = {w[30:0], w[31]};
                end
                w = sched[r & 15];
                if (r < 20) begin
                    f = (b & c) | (~b & d);
                    k = sfbc_pkg::K0;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = sfbc_pkg::K1;
                end else if (r < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = sfbc_pkg::K2;
                end else begin
                    f = b ^ c ^ d;
                    k = sfbc_pkg::K3;
                end
                t = {a[26:0], a[31:27]} + f + e + k + w;
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            digest[0] += a;
            digest[1] += b;
            digest[2] += c;
            digest[3] += d;
            digest[4] += e;
        endfunction

        // padding, bit length, then xor-fold of the 20 digest bytes
        function bit [31:0] close_block();
            int unsigned pos;
            bit [63:0]   bits;
            bit [7:0]    x;
            bit [31:0]   folded;
            pos  = count & 63;
            bits = 64'(count) * 64'd8;
            put_byte(pos, 8'h80);
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    put_byte(pos, 8'h00);
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56) begin
                put_byte(pos, 8'h00);
                pos++;
            end
            sched[14] = bits[63:32];
            sched[15] = bits[31:0];
            compress();
            folded = '0;
            for (int g = 0; g < 4; g++) begin
                x = '0;
                for (int i = 5 * g; i < 5 * g + 5; i++) begin
                    x ^= digest[i >> 2][(3 - (i & 3)) * 8 +: 8];
                end
                folded = {folded[23:0], x};
            end
            return folded;
        endfunction

        function void note_byte(bit [7:0] data, bit last);
            bit [7:0]     v;
            block_check_t res;
            if (count >= sfbc_pkg::MAX_MESSAGE_BYTES) begin
                overflow = 1'b1;
            end else begin
                v = data;
                if (count >= sfbc_pkg::CHECK_OFFSET &&
                    count < sfbc_pkg::CHECK_OFFSET + sfbc_pkg::CHECK_BYTES) begin
                    stored[(sfbc_pkg::CHECK_OFFSET + sfbc_pkg::CHECK_BYTES - 1 - count) * 8
                           +: 8] = data;
                    v = 8'h00;
                end
                put_byte(count & 63, v);
                if ((count & 63) == 63) compress();
                count++;
            end
            if (last) begin
                res.value    = close_block();
                res.is_match = (res.value == stored);
                res.overflow = overflow;
                expected.push_back(res);
                clear();
            end
        endfunction

        task report(string what);
            if (errors < 50) $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [31:0] value, logic is_match, logic ovf);
            block_check_t e;
            if (expected.size() == 0) begin
                report($sformatf("result with no block pending, check_value=%h", value));
                return;
            end
            e = expected.pop_front();
            results_checked++;
            if (value !== e.value)
                report($sformatf("check_value %h, expected %h", value, e.value));
            if (is_match !== e.is_match)
                report($sformatf("check_matches %b, expected %b", is_match, e.is_match));
            if (ovf !== e.overflow)
                report($sformatf("length_overflow %b, expected %b", ovf, e.overflow));
        endtask

    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] check_value;
    logic        check_matches;
    logic        length_overflow;

    check_scoreboard sb = new();
    bit [7:0]        block_bytes[$];
    bit              send_burst = 1'b0;
    bit              recv_burst = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sha1_folded_block_check dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .empty           (empty),
        .pop             (pop),
        .check_value     (check_value),
        .check_matches   (check_matches),
        .length_overflow (length_overflow)
    );

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_length();
        int r;
        int edges[14] = '{13, 14, 17, 18, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        r = $urandom_range(0, 99);
        if (r < 20) return edges[$urandom_range(0, 13)];
        if (r < 75) return $urandom_range(1, 80);
        return $urandom_range(81, 200);
    endfunction

    // a matched block carries its own folded digest in bytes 14 to 17
    function automatic void fill_block(int len, bit matched);
        check_scoreboard scratch;
        bit [31:0]       folded;
        block_bytes.delete();
        for (int i = 0; i < len; i++) block_bytes.push_back(8'($urandom_range(0, 255)));
        if (matched) begin
            scratch = new();
            foreach (block_bytes[i]) scratch.note_byte(block_bytes[i], i == len - 1);
            folded = scratch.expected[0].value;
            for (int i = 0; i < sfbc_pkg::CHECK_BYTES; i++)
                block_bytes[sfbc_pkg::CHECK_OFFSET + i] = folded[31 - 8 * i -: 8];
        end
    endfunction

    // full is decoded from registers only: its value at the falling edge holds at the next rise
    task automatic send_byte(bit [7:0] d, bit last);
        int gap;
        gap = pick_gap(send_burst);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= d;
        last_byte <= last;
        @(negedge clk);
        while (full) @(negedge clk);
        @(posedge clk);
        sb.note_byte(d, last);
    endtask

    task automatic send_block();
        foreach (block_bytes[i]) send_byte(block_bytes[i], i == block_bytes.size() - 1);
    endtask

    initial begin
        int  body_bytes;
        int  blocks;
        int  len;
        bit  matched;
        body_bytes = 0;
        blocks = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte blocks at both byte extremes
        block_bytes = '{8'h00};
        send_block();
        block_bytes = '{8'hFF};
        send_block();
        // short block: only byte 14 of the stored check arrives
        fill_block(15, 1'b0);
        send_block();

        while (body_bytes < 1900 || blocks <= 12) begin
            if (blocks == 12) len = sfbc_pkg::MAX_MESSAGE_BYTES + 1;
            else len = pick_length();
            matched = (len >= sfbc_pkg::CHECK_OFFSET + sfbc_pkg::CHECK_BYTES) &&
                      ($urandom_range(0, 1) == 1);
            fill_block(len, matched);
            send_block();
            if (len < sfbc_pkg::MAX_MESSAGE_BYTES) body_bytes += len;
            blocks++;
            send_burst = ($urandom_range(0, 5) == 0);
        end
        push <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        int          gap;
        bit          held;
        logic [31:0] got_value;
        logic        got_match;
        logic        got_ovf;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = pick_gap(recv_burst);
            // one long hold-off so the block backs up to its input
            if (!held && sb.results_checked == 6) begin
                held = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(negedge clk);
            while (empty) @(negedge clk);
            got_value = check_value;
            got_match = check_matches;
            got_ovf   = length_overflow;
            @(posedge clk);
            sb.check_result(got_value, got_match, got_ovf);
            recv_burst = ($urandom_range(0, 7) == 0);
        end
    end

    initial begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if ((push && !full) || (pop && !empty)) idle = 0;
            else idle++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
